### rtl/tufn_pkg.sv
// Shared types, constants and helper functions for the triangle face normal unit.
package tufn_pkg;

  // Parameter defaults
  localparam int COORD_WIDTH_DEF      = 24;
  localparam int COORD_FRAC_BITS_DEF  = 12;
  localparam int NORMAL_FRAC_BITS_DEF = 16;

  // Fixed internal widths
  localparam int OUT_W  = 18;  // one normal component
  localparam int MAG_W  = 31;  // reduced cross magnitude
  localparam int SUM_W  = 64;  // sum of squares
  localparam int ROOT_W = 32;  // square root of the sum
  localparam int SH_W   = 7;   // bit length / shift amount

  // Side data that travels alongside the square root
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  degen;
  } side_t;

  // Bit length of a 64-bit magnitude (0 for zero)
  function automatic logic [SH_W-1:0] bit_len(input logic [63:0] x);
    logic [SH_W-1:0] bl;
    bl = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) bl = SH_W'(i + 1);
    end
    return bl;
  endfunction

  // Right shift needed so a value of bit length bl fits in 31 bits
  function automatic logic [SH_W-1:0] fit_shift(input logic [SH_W-1:0] bl);
    return (bl > SH_W'(MAG_W)) ? (bl - SH_W'(MAG_W)) : '0;
  endfunction

endpackage

### rtl/tufn_front.sv
// Edge vectors, cross product, range reduction and sum of squares (7 stages).
module tufn_front #(
  parameter int COORD_WIDTH = tufn_pkg::COORD_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       en,
  input  logic                                       in_valid,
  input  logic [9*COORD_WIDTH-1:0]                   in_data,
  output logic                                       out_valid,
  output logic [tufn_pkg::SUM_W-1:0]                 out_sum,
  output tufn_pkg::side_t                            out_side
);
  localparam int EW = COORD_WIDTH + 1;
  localparam int MW = tufn_pkg::MAG_W;

  logic [6:0] vld;

  // stage 1: edges
  logic signed [EW-1:0] e1 [3], e2 [3];
  logic signed [EW-1:0] e1_next [3], e2_next [3];
  logic [EW-1:0] emax_or, emax_or_next;

  always_comb begin
    logic signed [COORD_WIDTH-1:0] v [9];
    logic [EW-1:0] m1, m2;
    emax_or_next = '0;
    for (int i = 0; i < 9; i++) v[i] = $signed(in_data[i*COORD_WIDTH +: COORD_WIDTH]);
    for (int i = 0; i < 3; i++) begin
      e1_next[i] = EW'(v[3+i]) - EW'(v[i]);
      e2_next[i] = EW'(v[6+i]) - EW'(v[i]);
      m1 = e1_next[i][EW-1] ? EW'(-e1_next[i]) : EW'(e1_next[i]);
      m2 = e2_next[i][EW-1] ? EW'(-e2_next[i]) : EW'(e2_next[i]);
      emax_or_next = emax_or_next | m1 | m2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1 <= e1_next;
      e2 <= e2_next;
      emax_or <= emax_or_next;
    end
  end

  // stage 2: halve wide edges until they fit 31 bits
  logic signed [31:0] a [3], b [3];
  logic signed [31:0] a_next [3], b_next [3];

  always_comb begin
    logic [tufn_pkg::SH_W-1:0] s1;
    logic [EW-1:0] m1, m2;
    logic [31:0] t1, t2;
    s1 = tufn_pkg::fit_shift(tufn_pkg::bit_len(64'(emax_or)));
    for (int i = 0; i < 3; i++) begin
      m1 = e1[i][EW-1] ? EW'(-e1[i]) : EW'(e1[i]);
      m2 = e2[i][EW-1] ? EW'(-e2[i]) : EW'(e2[i]);
      t1 = 32'(m1 >> s1);
      t2 = 32'(m2 >> s1);
      a_next[i] = e1[i][EW-1] ? $signed(-t1) : $signed(t1);
      b_next[i] = e2[i][EW-1] ? $signed(-t2) : $signed(t2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a <= a_next;
      b <= b_next;
    end
  end

  // stage 3: six partial products
  logic signed [63:0] p [6];
  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= a[1] * b[2];
      p[1] <= a[2] * b[1];
      p[2] <= a[2] * b[0];
      p[3] <= a[0] * b[2];
      p[4] <= a[0] * b[1];
      p[5] <= a[1] * b[0];
    end
  end

  // stage 4: cross product, magnitudes and signs
  logic [63:0] cmag [3];
  logic [2:0]  cneg;
  logic [63:0] cor;

  always_ff @(posedge clk) begin
    logic signed [63:0] c [3];
    if (en) begin
      c[0] = p[0] - p[1];
      c[1] = p[2] - p[3];
      c[2] = p[4] - p[5];
      for (int i = 0; i < 3; i++) begin
        cmag[i] <= c[i][63] ? 64'(-c[i]) : 64'(c[i]);
        cneg[i] <= c[i][63];
      end
      cor <= (c[0][63] ? 64'(-c[0]) : 64'(c[0])) |
             (c[1][63] ? 64'(-c[1]) : 64'(c[1])) |
             (c[2][63] ? 64'(-c[2]) : 64'(c[2]));
    end
  end

  // stage 5: common shift to 31 bits, degenerate detect
  logic [MW-1:0] rmag [3];
  logic [2:0]    rneg;
  logic          rdeg;

  always_ff @(posedge clk) begin
    logic [tufn_pkg::SH_W-1:0] s2;
    if (en) begin
      s2 = tufn_pkg::fit_shift(tufn_pkg::bit_len(cor));
      for (int i = 0; i < 3; i++) rmag[i] <= MW'(cmag[i] >> s2);
      rneg <= cneg;
      rdeg <= (cor == '0);
    end
  end

  // stage 6: squares
  logic [2*MW-1:0] sq [3];
  tufn_pkg::side_t side6, side7;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= rmag[i] * rmag[i];
        side6.mag[i] <= rmag[i];
      end
      side6.neg   <= rneg;
      side6.degen <= rdeg;
    end
  end

  // stage 7: sum of squares
  logic [tufn_pkg::SUM_W-1:0] sum;
  always_ff @(posedge clk) begin
    if (en) begin
      sum   <= tufn_pkg::SUM_W'(sq[0]) + tufn_pkg::SUM_W'(sq[1]) +
               tufn_pkg::SUM_W'(sq[2]);
      side7 <= side6;
    end
  end

  // valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  assign out_valid = vld[6];
  assign out_sum   = sum;
  assign out_side  = side7;

endmodule

### rtl/tufn_isqrt.sv
// Pipelined integer square root, two radicand bits per stage.
module tufn_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [tufn_pkg::SUM_W-1:0]    in_x,
  input  tufn_pkg::side_t               in_side,
  output logic                          out_valid,
  output logic [tufn_pkg::ROOT_W-1:0]   out_root,
  output tufn_pkg::side_t               out_side
);
  localparam int NS = tufn_pkg::ROOT_W;
  localparam int XW = tufn_pkg::SUM_W;
  localparam int RW = tufn_pkg::ROOT_W + 3;

  logic [XW-1:0]               xs   [NS+1];
  logic [tufn_pkg::ROOT_W-1:0] rt   [NS+1];
  logic [RW-1:0]               rem  [NS+1];
  tufn_pkg::side_t             sd   [NS+1];
  logic [NS:0]                 vld;

  assign xs[0]  = in_x;
  assign rt[0]  = '0;
  assign rem[0] = '0;
  assign sd[0]  = in_side;
  assign vld[0] = in_valid;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RW-1:0] r2, trial;
    logic          ge;
    // bring down two bits, try subtracting 4*root+1
    always_comb begin
      r2    = {rem[k][RW-3:0], xs[k][XW-1 -: 2]};
      trial = RW'({rt[k], 2'b01});
      ge    = (r2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k+1]  <= {xs[k][XW-3:0], 2'b00};
        rem[k+1] <= ge ? (r2 - trial) : r2;
        rt[k+1]  <= {rt[k][tufn_pkg::ROOT_W-2:0], ge};
        sd[k+1]  <= sd[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  assign out_valid = vld[NS];
  assign out_root  = rt[NS];
  assign out_side  = sd[NS];

endmodule

### rtl/tufn_div.sv
// Pipelined restoring division of each magnitude by the length, one quotient bit per stage.
module tufn_div #(
  parameter int NORMAL_FRAC_BITS = tufn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [tufn_pkg::ROOT_W-1:0]            in_len,
  input  tufn_pkg::side_t                        in_side,
  output logic                                   out_valid,
  output logic [2:0][tufn_pkg::OUT_W-1:0]        out_normal,
  output logic                                   out_degen
);
  localparam int QW = NORMAL_FRAC_BITS + 1;
  localparam int LW = tufn_pkg::ROOT_W;
  localparam int XW = ((QW > tufn_pkg::OUT_W) ? QW : tufn_pkg::OUT_W) + 1;

  logic [LW-1:0]   len  [QW+1];
  logic [LW-1:0]   rem  [QW+1][3];
  logic [QW-1:0]   quo  [QW+1][3];
  logic [2:0]      neg  [QW+1];
  logic            deg  [QW+1];
  logic [2:0]      lsb;
  logic [QW:0]     vld;

  // seed: numerator high part is mag >> 1, its low bit enters first
  always_comb begin
    len[0] = (in_len == '0) ? LW'(1) : in_len;
    for (int i = 0; i < 3; i++) begin
      rem[0][i] = LW'(in_side.mag[i] >> 1);
      quo[0][i] = '0;
      lsb[i]    = in_side.mag[i][0];
    end
    neg[0]  = in_side.neg;
    deg[0]  = in_side.degen;
    vld[0]  = in_valid;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [LW:0] r2;
      logic        ge;
      always_comb begin
        r2 = {rem[k][i], (k == 0) ? lsb[i] : 1'b0};
        ge = (r2 >= {1'b0, len[k]});
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1][i] <= LW'(ge ? (r2 - {1'b0, len[k]}) : r2);
          quo[k+1][i] <= {quo[k][i][QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len[k+1] <= len[k];
        neg[k+1] <= neg[k];
        deg[k+1] <= deg[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  // apply sign, keep the low output bits
  always_comb begin
    logic [XW-1:0] qx;
    for (int i = 0; i < 3; i++) begin
      qx = XW'(quo[QW][i]);
      out_normal[i] = tufn_pkg::OUT_W'(neg[QW][i] ? (XW'(0) - qx) : qx);
    end
  end

  assign out_valid = vld[QW];
  assign out_degen = deg[QW];

endmodule

### rtl/tufn_outbuf.sv
// Output register with skid stage; stalls the pipeline only when the skid holds a word.
module tufn_outbuf #(
  parameter int DW = 56
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_data,
  input  logic          in_user,
  output logic          en,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_data,
  output logic          out_user
);
  logic          skid_valid;
  logic [DW-1:0] skid_data;
  logic          skid_user;
  logic          push;

  assign en   = ~skid_valid;
  assign push = en & in_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) skid_valid <= 1'b0;
    end else if (push) begin
      if (out_valid && !out_ready) skid_valid <= 1'b1;
      else out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_data <= skid_data;
        out_user <= skid_user;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_data <= in_data;
        skid_user <= in_user;
      end else begin
        out_data <= in_data;
        out_user <= in_user;
      end
    end
  end

endmodule

### rtl/triangle_unit_face_normal.sv
// Top level: unit face normal of one triangle per word.
//
// Input stream: s_tvalid/s_tready/s_tdata carries the nine vertex
// coordinates of one triangle (first, second, third vertex; x, y, z each).
// Output stream: m_tvalid/m_tready/m_tdata carries the unit normal in
// signed Q1.16 (x, y, z); m_tuser flags a degenerate triangle, for which
// the normal reads as zero.
// Pipeline: the 7-stage cross product front end, the 32-stage square root,
// one stage per quotient bit in the divider, and the output register.
// Throughput: one triangle per cycle while s_tready is high; all stages advance together.
// Stalls: the output register is backed by a one-word skid stage. When the
// receiver holds m_tready low and the skid fills, s_tready drops and the
// whole pipeline holds; no word is lost or repeated.
// Reset: rst (synchronous) empties the pipeline and the output buffer.
// The coordinate fraction width cancels in the ratio and changes no result.
module triangle_unit_face_normal #(
  parameter int COORD_WIDTH      = tufn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = tufn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // first_x, first_y, first_z, second_x..z, third_x..z, zero pad
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // normal_x, normal_y, normal_z, zero pad
  output logic [((3*tufn_pkg::OUT_W+7)/8)*8-1:0]    m_tdata,
  // degenerate
  output logic                                     m_tuser
);
  localparam int OW = ((3*tufn_pkg::OUT_W+7)/8)*8;

  logic                          en;
  logic                          f_valid;
  logic [tufn_pkg::SUM_W-1:0]    f_sum;
  tufn_pkg::side_t               f_side;
  logic                          q_valid;
  logic [tufn_pkg::ROOT_W-1:0]   q_root;
  tufn_pkg::side_t               q_side;
  logic                          d_valid;
  logic [2:0][tufn_pkg::OUT_W-1:0] d_normal;
  logic                          d_degen;
  logic [OW-1:0]                 d_word;

  assign s_tready = en;

  tufn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid),
    .in_data(s_tdata[9*COORD_WIDTH-1:0]),
    .out_valid(f_valid), .out_sum(f_sum), .out_side(f_side)
  );

  tufn_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(f_valid), .in_x(f_sum), .in_side(f_side),
    .out_valid(q_valid), .out_root(q_root), .out_side(q_side)
  );

  tufn_div #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(q_valid), .in_len(q_root), .in_side(q_side),
    .out_valid(d_valid), .out_normal(d_normal), .out_degen(d_degen)
  );

  assign d_word = OW'(d_normal);

  tufn_outbuf #(.DW(OW)) u_outbuf (
    .clk(clk), .rst(rst),
    .in_valid(d_valid), .in_data(d_word), .in_user(d_degen),
    .en(en),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_data(m_tdata), .out_user(m_tuser)
  );

endmodule

### rtl/tufn_check.sv
// Port-level checks for the face normal unit, bound to the top level.
module tufn_check #(
  parameter int IW = 216,
  parameter int OW = 56
) (
  input logic          clk,
  input logic          rst,
  input logic          s_tvalid,
  input logic          s_tready,
  input logic [IW-1:0] s_tdata,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [OW-1:0] m_tdata,
  input logic          m_tuser
);
  localparam int NW = 3 * tufn_pkg::OUT_W;

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed under stall");

  // degenerate words carry a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[NW-1:0] == '0)
    else $error("degenerate word with nonzero normal");

  // a real normal is never all zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[NW-1:0] != '0)
    else $error("zero normal without degenerate flag");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // input side only stalls while a word waits at the output
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

endmodule

bind triangle_unit_face_normal tufn_check #(
  .IW(((9*COORD_WIDTH+7)/8)*8),
  .OW(((3*tufn_pkg::OUT_W+7)/8)*8)
) u_tufn_check (
  .clk(clk), .rst(rst),
  .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

### test/tb_triangle_unit_face_normal.sv
// Testbench for the triangle face normal unit: directed and random triangles vs. a predictor.
module tb_triangle_unit_face_normal;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW   = tufn_pkg::COORD_WIDTH_DEF;
  localparam int NFB  = tufn_pkg::NORMAL_FRAC_BITS_DEF;
  localparam int OW   = tufn_pkg::OUT_W;
  localparam int IN_W = ((9 * CW + 7) / 8) * 8;
  localparam int MD_W = ((3 * OW + 7) / 8) * 8;
  localparam int LATENCY = 7 + 32 + (NFB + 1) + 1;

  typedef struct packed {
    logic [OW-1:0] nx;
    logic [OW-1:0] ny;
    logic [OW-1:0] nz;
    logic          degen;
  } normal_t;

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata;
  logic            m_tvalid;
  logic            m_tready;
  logic [MD_W-1:0] m_tdata;
  logic            m_tuser;

  normal_t normal_q[$];
  int      n_errors;
  int      hold_cycles;   // long receiver hold-off request
  bit      rx_busy;       // receiver stall pattern enabled

  triangle_unit_face_normal u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Integer square root, floor
  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag64(input longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  // Expected unit normal for nine coordinates
  function automatic normal_t face_normal(input logic [IN_W-1:0] tri_word);
    longint          v[9];
    longint          e1[3], e2[3], c[3];
    longint unsigned m[3], maxm, sum, len, q;
    int              sh;
    int              bl;
    normal_t         r;
    for (int i = 0; i < 9; i++) v[i] = longint'($signed(tri_word[i*CW +: CW]));
    maxm = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = v[3+i] - v[i];
      e2[i] = v[6+i] - v[i];
      if (mag64(e1[i]) > maxm) maxm = mag64(e1[i]);
      if (mag64(e2[i]) > maxm) maxm = mag64(e2[i]);
    end
    // edges shrink only for coordinates of 32 bits or more
    sh = 0;
    while ((maxm >> sh) >= (64'd1 << 31)) sh++;
    for (int i = 0; i < 3; i++) begin
      e1[i] = (e1[i] < 0) ? -longint'(mag64(e1[i]) >> sh) : longint'(mag64(e1[i]) >> sh);
      e2[i] = (e2[i] < 0) ? -longint'(mag64(e2[i]) >> sh) : longint'(mag64(e2[i]) >> sh);
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    maxm = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag64(c[i]);
      if (m[i] > maxm) maxm = m[i];
    end
    r = '0;
    if (maxm == 0) begin
      r.degen = 1'b1;
      return r;
    end
    bl = 0;
    while (bl < 64 && (maxm >> bl) != 0) bl++;
    sh  = (bl > 31) ? bl - 31 : 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] >>= sh;
      sum += m[i] * m[i];
    end
    len = floor_sqrt(sum);
    if (len == 0) len = 1;
    q = (m[0] << NFB) / len;
    r.nx = (c[0] < 0) ? OW'(-q) : OW'(q);
    q = (m[1] << NFB) / len;
    r.ny = (c[1] < 0) ? OW'(-q) : OW'(q);
    q = (m[2] << NFB) / len;
    r.nz = (c[2] < 0) ? OW'(-q) : OW'(q);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [OW-1:0] got,
                                 input logic [OW-1:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Send one triangle word; random gaps come from the burst controller
  int burst_left;
  task automatic send_triangle(input logic [IN_W-1:0] w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    normal_q.push_back(face_normal(w));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] pack_tri(input logic [8:0][CW-1:0] c);
    logic [IN_W-1:0] w;
    w = '0;
    for (int i = 0; i < 9; i++) w[i*CW +: CW] = c[i];
    return w;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(0, 2000)) - 1000);
      2: return {1'b1, {(CW-1){1'b0}}};
      3: return {1'b0, {(CW-1){1'b1}}};
      default: return CW'($urandom) >> $urandom_range(0, CW - 1);
    endcase
  endfunction

  // Receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_tready    <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_busy) begin
      m_tready <= ($urandom_range(0, 2) != 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    normal_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (normal_q.size() == 0) begin
        report_mismatch("unexpected word", m_tdata[0 +: OW], '0);
      end else begin
        want = normal_q.pop_front();
        if (m_tdata[0 +: OW] !== want.nx) report_mismatch("normal_x", m_tdata[0 +: OW], want.nx);
        if (m_tdata[OW +: OW] !== want.ny) report_mismatch("normal_y", m_tdata[OW +: OW], want.ny);
        if (m_tdata[2*OW +: OW] !== want.nz)
          report_mismatch("normal_z", m_tdata[2*OW +: OW], want.nz);
        if (m_tuser !== want.degen) report_mismatch("degenerate", OW'(m_tuser), OW'(want.degen));
        if (m_tdata[MD_W-1:3*OW] !== '0)
          report_mismatch("pad", OW'(m_tdata[MD_W-1:3*OW]), '0);
      end
    end
  end

  // Extremes, axis-aligned triangles and degenerate cases
  task automatic test_directed();
    logic [CW-1:0] mx, mn, z, one;
    mx  = {1'b0, {(CW-1){1'b1}}};
    mn  = {1'b1, {(CW-1){1'b0}}};
    z   = '0;
    one = CW'(4096);
    send_triangle(pack_tri({z, z, z, z, one, z, z, z, one}));
    send_triangle(pack_tri({z, one, z, z, z, one, z, z, z}));
    send_triangle(pack_tri({one, z, z, z, z, one, z, z, z}));
    send_triangle(pack_tri({z, z, z, z, z, z, z, z, z}));
    send_triangle(pack_tri({one, one, one, one, one, one, one, one, one}));
    send_triangle(pack_tri({mx, mx, mx, z, z, z, mn, mn, mn}));
    send_triangle(pack_tri({mn, mn, mx, mx, mn, mn, mn, mx, mn}));
    send_triangle(pack_tri({mx, mn, mx, mn, mx, mn, mx, mn, mx}));
    send_triangle(pack_tri({z, mx, z, mn, z, z, z, z, mn}));
    send_triangle(pack_tri({mx, z, z, z, mn, z, z, z, mx}));
    send_triangle(pack_tri({CW'(1), z, z, z, CW'(1), z, z, z, z}));
    send_triangle(pack_tri({{CW{1'b1}}, {CW{1'b1}}, {CW{1'b1}}, z, z, z, z, z, z}));
    send_triangle(pack_tri({z, CW'(3), CW'(7), z, CW'(1), CW'(5), z, z, z}));
    send_triangle(pack_tri({mx, mx, mx, mn, mn, mn, mx, mn, mx}));
  endtask

  // Random triangles, with a share of collinear ones
  task automatic test_random(input int count);
    logic [8:0][CW-1:0] c;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 9; i++) c[i] = rand_coord();
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < 3; i++) c[6+i] = c[i];
      end
      send_triangle(pack_tri(c));
    end
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    hold_cycles = 200;
    test_random(120);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    n_errors    = 0;
    hold_cycles = 0;
    rx_busy     = 1'b0;
    burst_left  = 0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    rx_busy = 1'b1;
    test_random(200);
    test_backpressure();
    rx_busy = 1'b0;
    test_random(100);
    rx_busy = 1'b1;
    test_random(120);
    wait_drained();
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TIMEOUT");
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
rtl/tufn_pkg.sv
rtl/tufn_front.sv
rtl/tufn_isqrt.sv
rtl/tufn_div.sv
rtl/tufn_outbuf.sv
rtl/triangle_unit_face_normal.sv
rtl/tufn_check.sv
test/tb_triangle_unit_face_normal.sv
